>>> hdl/btg_pkg.sv
`timescale 1ns / 1ps

package btg_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER_MODE  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_DURATION = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_TARGET  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_WINDOW  = 3'd4;

   typedef enum logic [1:0] {
      MODE_SINGLE_PRESS = 2'd0,
      MODE_KEEP_HELD    = 2'd1,
      MODE_HOLD         = 2'd2,
      MODE_MULTI_PRESS  = 2'd3
   } mode_type;

   localparam logic        RST_ENABLE        = 1'b1;
   localparam mode_type    RST_TRIGGER_MODE  = MODE_SINGLE_PRESS;
   localparam logic [15:0] RST_HOLD_DURATION = 16'd500;
   localparam logic [3:0]  RST_PRESS_TARGET  = 4'd2;
   localparam logic [15:0] RST_PRESS_WINDOW  = 16'd300;

   localparam logic [15:0] TIMER_MAX = 16'hFFFF;
   localparam logic [3:0]  COUNT_MAX = 4'hF;

   typedef struct packed {
      logic        enable;
      mode_type    trigger_mode;
      logic [15:0] hold_duration;
      logic [3:0]  press_target;
      logic [15:0] press_window;
   } cfg_type;

   typedef struct packed {
      logic               raw_down;
      logic signed [15:0] raw_value;
      logic [11:0]        delta_time;
   } item_type;

   typedef struct packed {
      logic               active;
      logic               just_activated;
      logic               just_deactivated;
      logic signed [15:0] action_value;
   } result_type;

endpackage

>>> hdl/button_gesture_trigger_unit.sv
`timescale 1ns / 1ps
// Channel | Ports                         | Direction | Handshake
// req     | raw_down, raw_value, delta_time | in      | req_valid / req_ready
// rsp     | active, just_activated, just_deactivated, action_value
//         |                               | out       | rsp_valid / rsp_ready
// csr     | csr_we, csr_index, csr_wdata  | in        | write enable, no wait
//
// One item per cycle sustained while rsp is not stalled; an accepted req passes through
// the input register, then the result register, before rsp_valid rises.
// Gesture state is updated as an item moves from the input register to the result register.
// Synchronous active-high reset clears valids and gesture state; config returns to defaults.
// A stalled rsp holds the result; one more item waits in the input register.

module button_gesture_trigger_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_raw_down,
   input  logic signed [15:0]                   req_raw_value,
   input  logic [11:0]                          req_delta_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_active,
   output logic                                 rsp_just_activated,
   output logic                                 rsp_just_deactivated,
   output logic signed [15:0]                   rsp_action_value,
   input  logic                                 csr_we,
   input  logic [btg_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [btg_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   btg_pkg::cfg_type    cfg;
   btg_pkg::item_type   item_ff, item_in;
   btg_pkg::result_type result;
   btg_pkg::result_type result_ff;
   logic                s1_valid_ff, s1_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;

   btg_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   btg_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg),
      .item   (item_ff),
      .result (result)
   );

   assign advance   = s1_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~s1_valid_ff | advance;

   always_comb begin
      item_in.raw_down   = req_raw_down;
      item_in.raw_value  = req_raw_value;
      item_in.delta_time = req_delta_time;
      s1_valid_in  = (req_valid & req_ready) | (s1_valid_ff & ~advance);
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready)
         item_ff <= item_in;
      if (advance)
         result_ff <= result;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_active           = result_ff.active;
   assign rsp_just_activated   = result_ff.just_activated;
   assign rsp_just_deactivated = result_ff.just_deactivated;
   assign rsp_action_value     = result_ff.action_value;

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("pending item dropped");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("stalled result overwritten");

endmodule

>>> hdl/btg_cfg.sv
`timescale 1ns / 1ps

module btg_cfg (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [btg_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [btg_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output btg_pkg::cfg_type                      cfg
);

   btg_pkg::cfg_type cfg_ff;
   btg_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            btg_pkg::CSR_ENABLE:        cfg_in.enable        = csr_wdata[0];
            btg_pkg::CSR_TRIGGER_MODE:
               cfg_in.trigger_mode = btg_pkg::mode_type'(csr_wdata[1:0]);
            btg_pkg::CSR_HOLD_DURATION: cfg_in.hold_duration = csr_wdata;
            btg_pkg::CSR_PRESS_TARGET:  cfg_in.press_target  = csr_wdata[3:0];
            btg_pkg::CSR_PRESS_WINDOW:  cfg_in.press_window  = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= btg_pkg::RST_ENABLE;
         cfg_ff.trigger_mode  <= btg_pkg::RST_TRIGGER_MODE;
         cfg_ff.hold_duration <= btg_pkg::RST_HOLD_DURATION;
         cfg_ff.press_target  <= btg_pkg::RST_PRESS_TARGET;
         cfg_ff.press_window  <= btg_pkg::RST_PRESS_WINDOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hdl/btg_core.sv
`timescale 1ns / 1ps

module btg_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  btg_pkg::cfg_type      cfg,
   input  btg_pkg::item_type     item,
   output btg_pkg::result_type   result
);

   logic               last_down_ff,  last_down_in;
   logic               active_ff,     active_in;
   logic [15:0]        hold_timer_ff, hold_timer_in;
   logic               hold_fired_ff, hold_fired_in;
   logic [3:0]         count_ff,      count_in;
   logic [15:0]        window_ff,     window_in;
   logic               rise_ff,       rise_in;
   logic               fall_ff,       fall_in;
   logic signed [15:0] value_ff,      value_in;

   logic        rise;
   logic        act;
   logic [16:0] hold_sum;
   logic [15:0] dt16;
   logic [3:0]  cnt;
   logic [15:0] win;

   always_comb begin
      rise     = item.raw_down & ~last_down_ff;
      dt16     = {4'd0, item.delta_time};
      hold_sum = {1'b0, hold_timer_ff} + {5'd0, item.delta_time};
      act      = 1'b0;
      cnt      = count_ff;
      win      = window_ff;

      last_down_in  = last_down_ff;
      active_in     = active_ff;
      hold_timer_in = hold_timer_ff;
      hold_fired_in = hold_fired_ff;
      count_in      = count_ff;
      window_in     = window_ff;
      rise_in       = rise_ff;
      fall_in       = fall_ff;
      value_in      = value_ff;

      if (cfg.enable) begin
         unique case (cfg.trigger_mode)
            btg_pkg::MODE_SINGLE_PRESS: act = rise;
            btg_pkg::MODE_KEEP_HELD:    act = item.raw_down;
            btg_pkg::MODE_HOLD: begin
               if (item.raw_down) begin
                  hold_timer_in = hold_sum[16] ? btg_pkg::TIMER_MAX : hold_sum[15:0];
                  if (hold_timer_in >= cfg.hold_duration)
                     hold_fired_in = 1'b1;
                  act = hold_fired_in;
               end else begin
                  hold_timer_in = '0;
                  hold_fired_in = 1'b0;
               end
            end
            btg_pkg::MODE_MULTI_PRESS: begin
               if (rise) begin
                  if (win != '0) begin
                     if (cnt != btg_pkg::COUNT_MAX)
                        cnt = cnt + 4'd1;
                  end else begin
                     cnt = 4'd1;
                  end
                  win = cfg.press_window;
               end
               // window expiry drops any partial count
               if (win != '0) begin
                  if (win <= dt16) begin
                     win = '0;
                     cnt = '0;
                  end else begin
                     win = win - dt16;
                  end
               end
               if (cnt >= cfg.press_target) begin
                  act = 1'b1;
                  cnt = '0;
                  win = '0;
               end
               count_in  = cnt;
               window_in = win;
            end
            default: act = 1'b0;
         endcase

         last_down_in = item.raw_down;
         active_in    = act;
         rise_in      = act & ~active_ff;
         fall_in      = ~act & active_ff;
         value_in     = act ? item.raw_value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_down_ff  <= 1'b0;
         active_ff     <= 1'b0;
         hold_timer_ff <= '0;
         hold_fired_ff <= 1'b0;
         count_ff      <= '0;
         window_ff     <= '0;
         rise_ff       <= 1'b0;
         fall_ff       <= 1'b0;
         value_ff      <= '0;
      end else if (step) begin
         last_down_ff  <= last_down_in;
         active_ff     <= active_in;
         hold_timer_ff <= hold_timer_in;
         hold_fired_ff <= hold_fired_in;
         count_ff      <= count_in;
         window_ff     <= window_in;
         rise_ff       <= rise_in;
         fall_ff       <= fall_in;
         value_ff      <= value_in;
      end
   end

   assign result.active           = active_in;
   assign result.just_activated   = rise_in;
   assign result.just_deactivated = fall_in;
   assign result.action_value     = value_in;

   a_edge_excl: assert property (@(posedge clock) disable iff (reset)
      !(rise_ff && fall_ff))
      else $error("both edge flags set");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (value_ff == '0))
      else $error("value not zero while inactive");

   a_rise_active: assert property (@(posedge clock) disable iff (reset)
      rise_ff |-> active_ff)
      else $error("rise flag without activation");

   a_hold_release: assert property (@(posedge clock) disable iff (reset)
      (step && cfg.enable && cfg.trigger_mode == btg_pkg::MODE_HOLD && !item.raw_down)
      |=> (hold_timer_ff == '0 && !hold_fired_ff))
      else $error("hold state not cleared on release");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 16;
   localparam int PHASE_ITEMS = 112;
   localparam int PRED_DEPTH  = 16;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   logic                            req_raw_down;
   logic signed [15:0]              req_raw_value;
   logic [11:0]                     req_delta_time;
   logic                            rsp_valid;
   logic                            rsp_ready;
   logic                            rsp_active;
   logic                            rsp_just_activated;
   logic                            rsp_just_deactivated;
   logic signed [15:0]              rsp_action_value;
   logic                            csr_we;
   logic [btg_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [btg_pkg::CSR_DATA_W-1:0]  csr_wdata;

   button_gesture_trigger_unit u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_raw_down         (req_raw_down),
      .req_raw_value        (req_raw_value),
      .req_delta_time       (req_delta_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_active           (rsp_active),
      .rsp_just_activated   (rsp_just_activated),
      .rsp_just_deactivated (rsp_just_deactivated),
      .rsp_action_value     (rsp_action_value),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // gesture tracker: settings and state as the block should hold them
   btg_pkg::cfg_type setting = '{btg_pkg::RST_ENABLE, btg_pkg::RST_TRIGGER_MODE,
                                 btg_pkg::RST_HOLD_DURATION, btg_pkg::RST_PRESS_TARGET,
                                 btg_pkg::RST_PRESS_WINDOW};
   logic        prev_down  = 1'b0;
   logic        is_active  = 1'b0;
   logic [15:0] hold_ms    = '0;
   logic        hold_done  = 1'b0;
   logic [3:0]  presses    = '0;
   logic [15:0] window_ms  = '0;
   logic        rose       = 1'b0;
   logic        fell       = 1'b0;
   logic [15:0] kept_value = '0;

   // predicted results in flight, oldest at the read pointer
   btg_pkg::result_type pred_buf [PRED_DEPTH];
   logic [3:0]          pred_wr_ptr = '0;
   logic [3:0]          pred_rd_ptr = '0;
   btg_pkg::result_type want;
   int          err_count = 0;
   int          src_idle_pct = 0;
   int          rcv_stall_pct = 0;
   int          dt_span = 120;
   int          idle_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic btg_pkg::result_type qualify_press(input btg_pkg::item_type it);
      btg_pkg::result_type r;
      logic        rise;
      logic        was_active;
      logic        act;
      logic [16:0] hsum;
      if (setting.enable) begin
         rise = it.raw_down && !prev_down;
         was_active = is_active;
         act = 1'b0;
         case (setting.trigger_mode)
            btg_pkg::MODE_SINGLE_PRESS: act = rise;
            btg_pkg::MODE_KEEP_HELD: act = it.raw_down;
            btg_pkg::MODE_HOLD: begin
               if (it.raw_down) begin
                  hsum = {1'b0, hold_ms} + 17'(it.delta_time);
                  hold_ms = hsum[16] ? btg_pkg::TIMER_MAX : hsum[15:0];
                  if (hold_ms >= setting.hold_duration)
                     hold_done = 1'b1;
                  act = hold_done;
               end else begin
                  hold_ms = '0;
                  hold_done = 1'b0;
               end
            end
            default: begin
               if (rise) begin
                  if (window_ms != 0) begin
                     if (presses != btg_pkg::COUNT_MAX)
                        presses = presses + 4'd1;
                  end else begin
                     presses = 4'd1;
                  end
                  window_ms = setting.press_window;
               end
               if (window_ms != 0) begin
                  if (window_ms <= 16'(it.delta_time)) begin
                     window_ms = '0;
                     presses = '0;
                  end else begin
                     window_ms = window_ms - 16'(it.delta_time);
                  end
               end
               if (presses >= setting.press_target) begin
                  act = 1'b1;
                  presses = '0;
                  window_ms = '0;
               end
            end
         endcase
         prev_down = it.raw_down;
         is_active = act;
         rose = act && !was_active;
         fell = !act && was_active;
         kept_value = act ? it.raw_value : 16'sd0;
      end
      r.active = is_active;
      r.just_activated = rose;
      r.just_deactivated = fell;
      r.action_value = kept_value;
      return r;
   endfunction

   function automatic void report_mismatch(input string field, input int exp_v, input int got_v);
      err_count++;
      $display("ERROR t=%0t %s: expected %0d, got %0d", $time, field, exp_v, got_v);
   endfunction

   function automatic logic [11:0] pick_delta();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return '0;
      if (roll < 14)
         return 12'hFFF;
      if (roll < 30)
         return 12'($urandom_range(4095));
      return 12'($urandom_range(dt_span));
   endfunction

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pred_wr_ptr == pred_rd_ptr) begin
            err_count++;
            $display("ERROR t=%0t unexpected result: active %0d value %0d", $time,
                     rsp_active, rsp_action_value);
         end else begin
            want = pred_buf[pred_rd_ptr];
            pred_rd_ptr = pred_rd_ptr + 4'd1;
            if (rsp_active !== want.active)
               report_mismatch("active", want.active, rsp_active);
            if (rsp_just_activated !== want.just_activated)
               report_mismatch("just_activated", want.just_activated, rsp_just_activated);
            if (rsp_just_deactivated !== want.just_deactivated)
               report_mismatch("just_deactivated", want.just_deactivated,
                               rsp_just_deactivated);
            if (rsp_action_value !== want.action_value)
               report_mismatch("action_value", want.action_value, rsp_action_value);
         end
      end
   end

   // nothing moving on either channel for too long means the block hung
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_tick(input logic down, input logic [15:0] value, input logic [11:0] dt);
      btg_pkg::item_type it;
      it.raw_down = down;
      it.raw_value = value;
      it.delta_time = dt;
      while ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_down <= it.raw_down;
      req_raw_value <= it.raw_value;
      req_delta_time <= it.delta_time;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      pred_buf[pred_wr_ptr] = qualify_press(it);
      pred_wr_ptr = pred_wr_ptr + 4'd1;
   endtask

   // hold off until every result is back so the block is idle
   task automatic settle();
      req_valid <= 1'b0;
      while (pred_wr_ptr != pred_rd_ptr)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [btg_pkg::CSR_INDEX_W-1:0] index,
                            input logic [btg_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         btg_pkg::CSR_ENABLE:        setting.enable = data[0];
         btg_pkg::CSR_TRIGGER_MODE:  setting.trigger_mode = btg_pkg::mode_type'(data[1:0]);
         btg_pkg::CSR_HOLD_DURATION: setting.hold_duration = data;
         btg_pkg::CSR_PRESS_TARGET:  setting.press_target = data[3:0];
         btg_pkg::CSR_PRESS_WINDOW:  setting.press_window = data;
         default: ;
      endcase
   endtask

   // alternating press / release runs with random content, plus some noise items
   task automatic run_gestures(input int count);
      int   sent;
      int   len;
      int   k;
      logic down;
      sent = 0;
      down = 1'b1;
      while (sent < count) begin
         if ($urandom_range(99) < 15) begin
            send_tick(1'($urandom_range(1)), 16'($urandom_range(65535)),
                      12'($urandom_range(4095)));
            sent++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            for (k = 0; k < len && sent < count; k++) begin
               send_tick(down, 16'($urandom_range(65535)), pick_delta());
               sent++;
            end
            down = !down;
         end
      end
   endtask

   task automatic test_single_press();
      send_tick(1'b0, 16'h7FFF, 12'd10);
      send_tick(1'b1, 16'h8000, 12'd10);
      send_tick(1'b1, 16'h1234, 12'd10);
      send_tick(1'b0, 16'h7FFF, 12'd10);
   endtask

   task automatic test_keep_held();
      settle();
      csr_write(btg_pkg::CSR_TRIGGER_MODE, 16'(btg_pkg::MODE_KEEP_HELD));
      send_tick(1'b1, 16'h0F0F, 12'd0);
      send_tick(1'b1, 16'hF0F0, 12'hFFF);
      send_tick(1'b0, 16'h5555, 12'd5);
   endtask

   task automatic test_hold();
      settle();
      csr_write(btg_pkg::CSR_TRIGGER_MODE, 16'(btg_pkg::MODE_HOLD));
      csr_write(btg_pkg::CSR_HOLD_DURATION, 16'd0);
      // zero duration fires on the first down tick
      send_tick(1'b1, 16'h2000, 12'd0);
      send_tick(1'b0, 16'h2000, 12'd0);
      settle();
      csr_write(btg_pkg::CSR_HOLD_DURATION, 16'd1000);
      send_tick(1'b1, 16'hAAAA, 12'hFFF);
      send_tick(1'b1, 16'h0001, 12'hFFF);
      send_tick(1'b0, 16'h0001, 12'd1);
   endtask

   task automatic test_multi_press();
      settle();
      csr_write(btg_pkg::CSR_TRIGGER_MODE, 16'(btg_pkg::MODE_MULTI_PRESS));
      csr_write(btg_pkg::CSR_PRESS_TARGET, 16'd2);
      csr_write(btg_pkg::CSR_PRESS_WINDOW, 16'd300);
      send_tick(1'b1, 16'h0100, 12'd50);
      send_tick(1'b0, 16'h0200, 12'd50);
      send_tick(1'b1, 16'h0300, 12'd50);
      send_tick(1'b0, 16'h0400, 12'd50);
      settle();
      // target of zero is met on every tick
      csr_write(btg_pkg::CSR_PRESS_TARGET, 16'd0);
      send_tick(1'b0, 16'hFFFF, 12'd3);
      settle();
      // no window: each press counts as the first
      csr_write(btg_pkg::CSR_PRESS_TARGET, 16'd2);
      csr_write(btg_pkg::CSR_PRESS_WINDOW, 16'd0);
      send_tick(1'b1, 16'h0010, 12'd1);
      send_tick(1'b0, 16'h0020, 12'd1);
      send_tick(1'b1, 16'h0030, 12'd1);
   endtask

   task automatic test_disabled();
      int idx;
      settle();
      csr_write(btg_pkg::CSR_TRIGGER_MODE, 16'(btg_pkg::MODE_KEEP_HELD));
      send_tick(1'b1, 16'h1234, 12'd10);
      settle();
      csr_write(btg_pkg::CSR_ENABLE, 16'd0);
      send_tick(1'b0, 16'hFFFB, 12'd7);
      send_tick(1'b1, 16'h4321, 12'd7);
      settle();
      // writes past the last register must be dropped
      for (idx = btg_pkg::CSR_PRESS_WINDOW + 1; idx < (1 << btg_pkg::CSR_INDEX_W); idx++)
         csr_write(idx[btg_pkg::CSR_INDEX_W-1:0], 16'($urandom_range(65535)));
      csr_write(btg_pkg::CSR_ENABLE, 16'd1);
   endtask

   task automatic test_random_gestures();
      int p;
      int kind;
      int idle_mode;
      for (p = 0; p < PHASES; p++) begin
         settle();
         kind = p % 8;
         idle_mode = (p / 4) % 4;
         src_idle_pct  = (idle_mode == 1) ? 66 : (idle_mode == 3) ? 15 : 0;
         rcv_stall_pct = (idle_mode == 2) ? 66 : (idle_mode == 3) ? 15 : 0;
         dt_span = (kind == 6) ? 4095 : ($urandom_range(1) ? 120 : 600);
         csr_write(btg_pkg::CSR_ENABLE, 16'd1);
         csr_write(btg_pkg::CSR_TRIGGER_MODE, 16'(p % 4));
         if (kind == 0) begin
            csr_write(btg_pkg::CSR_HOLD_DURATION, 16'd0);
            csr_write(btg_pkg::CSR_PRESS_TARGET, 16'd0);
            csr_write(btg_pkg::CSR_PRESS_WINDOW, 16'd0);
         end else if (kind >= 6) begin
            csr_write(btg_pkg::CSR_HOLD_DURATION, 16'hFFFF);
            csr_write(btg_pkg::CSR_PRESS_TARGET, 16'hFFFF);
            csr_write(btg_pkg::CSR_PRESS_WINDOW, 16'hFFFF);
         end else begin
            csr_write(btg_pkg::CSR_HOLD_DURATION, 16'($urandom_range(1500)));
            // upper bits of the narrow registers are don't-care
            csr_write(btg_pkg::CSR_PRESS_TARGET,
                      {12'($urandom_range(4095)), 4'($urandom_range(1, 4))});
            csr_write(btg_pkg::CSR_PRESS_WINDOW, 16'($urandom_range(50, 800)));
         end
         run_gestures(PHASE_ITEMS / 2);
         if (p % 3 == 0)
            settle();
         run_gestures(PHASE_ITEMS - PHASE_ITEMS / 2);
         if (p % 2 == 1) begin
            settle();
            csr_write(btg_pkg::CSR_ENABLE, 16'd0);
            run_gestures(6);
            settle();
            csr_write(btg_pkg::CSR_ENABLE, 16'd1);
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_raw_down = 1'b0;
      req_raw_value = '0;
      req_delta_time = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_press();
      test_keep_held();
      test_hold();
      test_multi_press();
      test_disabled();
      test_random_gestures();

      settle();
      repeat (8) @(posedge clock);
      if (err_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
hdl/btg_pkg.sv
hdl/btg_cfg.sv
hdl/btg_core.sv
hdl/button_gesture_trigger_unit.sv
test/tb.sv
